### src/hlv_pkg.sv
// Shared types, character constants and character class functions for the host name label validator.
`default_nettype none

package hlv_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [6:0] label_size_type;
   typedef logic [8:0] name_len_type;

   localparam byte_type CHAR_DOT    = 8'h2e;
   localparam byte_type CHAR_HYPHEN = 8'h2d;
   localparam byte_type CHAR_SPACE  = 8'h20;
   localparam byte_type CHAR_DEL    = 8'h7f;
   localparam byte_type CHAR_HIGH   = 8'h80;

   function automatic logic is_alnum(input byte_type b);
      logic result;
      begin
         result = (b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
         return result;
      end
   endfunction

   function automatic logic is_rejected(input byte_type b);
      logic result;
      begin
         result = (b >= CHAR_HIGH) || (b <= CHAR_SPACE) || (b == CHAR_DEL);
         return result;
      end
   endfunction

endpackage

`default_nettype wire

### src/hostname_label_validator_unit.sv
// Host name label validator: one name byte per word in, one verdict per name out.
//
// Usage:
//   The req channel carries one word per unstalled cycle: req_name_byte,
//   req_last_byte and req_empty_name. A word is taken when req_valid is high
//   and req_stall is low. The word with req_last_byte set closes the name; one
//   rsp word then carries rsp_name_valid (1 for a valid LDH host name). Other
//   words give no response. A closing word's verdict passes through the input
//   register, then the result register.
//   Throughput: one word per cycle unless a closing word waits on rsp_stall;
//   the label/name state update between the two registers is combinational.
//   When rsp_stall holds a verdict, the input stage keeps taking non-closing
//   words; a closing word waits in the input register until the result
//   register frees up, and req_stall rises while it waits.
//   Reset (synchronous, active high) drops both registers and clears all
//   label and name state. State also clears after every verdict.
`default_nettype none

module hostname_label_validator_unit #(
   parameter int MAX_NAME_LEN  = 255,
   parameter int MAX_LABEL_LEN = 63
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hlv_pkg::byte_type req_name_byte,
   input  wire logic              req_last_byte,
   input  wire logic              req_empty_name,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_name_valid
);
   import hlv_pkg::*;

   localparam label_size_type LabelMax = label_size_type'(MAX_LABEL_LEN);
   localparam label_size_type LabelSat = label_size_type'(MAX_LABEL_LEN + 1);
   localparam name_len_type   NameMax  = name_len_type'(MAX_NAME_LEN);
   localparam name_len_type   NameSat  = name_len_type'(MAX_NAME_LEN + 1);

   logic           in_valid_ff, in_valid_in;
   byte_type       in_byte_ff;
   logic           in_last_ff;
   logic           in_empty_ff;

   label_size_type label_size_ff, label_size_in;
   logic           has_char_ff, has_char_in;
   logic           ends_hyph_ff, ends_hyph_in;
   name_len_type   name_len_ff, name_len_in;
   logic           failed_ff, failed_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_name_valid_ff, rsp_name_valid_in;

   logic           out_free;
   logic           in_move;
   logic           take_req;

   label_size_type n_label_size;
   logic           n_has_char;
   logic           n_ends_hyph;
   name_len_type   n_name_len;
   logic           n_failed;
   logic           label_good;
   label_size_type label_bump;
   logic           verdict;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !in_move;
   assign take_req  = req_valid && !req_stall;

   assign label_good = has_char_ff && !ends_hyph_ff && (label_size_ff <= LabelMax);
   assign label_bump = (label_size_ff < LabelSat) ? label_size_ff + 7'd1 : label_size_ff;

   always_comb begin
      n_label_size = label_size_ff;
      n_has_char   = has_char_ff;
      n_ends_hyph  = ends_hyph_ff;
      n_name_len   = name_len_ff;
      n_failed     = failed_ff;
      if (in_empty_ff) begin
         n_failed = 1'b1;
      end else begin
         if (name_len_ff < NameSat) begin
            n_name_len = name_len_ff + 9'd1;
         end
         if (!failed_ff) begin
            if (is_rejected(in_byte_ff)) begin
               n_failed = 1'b1;
            end else if (in_byte_ff == CHAR_DOT) begin
               if (label_good) begin
                  n_label_size = '0;
                  n_has_char   = 1'b0;
                  n_ends_hyph  = 1'b0;
               end else begin
                  n_failed = 1'b1;
               end
            end else if (is_alnum(in_byte_ff)) begin
               n_label_size = label_bump;
               n_has_char   = 1'b1;
               n_ends_hyph  = 1'b0;
            end else if (in_byte_ff == CHAR_HYPHEN) begin
               if (!has_char_ff) begin
                  n_failed = 1'b1;
               end else begin
                  n_label_size = label_bump;
                  n_ends_hyph  = 1'b1;
               end
            end else begin
               n_failed = 1'b1;
            end
         end
      end
      verdict = !n_failed && (n_name_len <= NameMax) && n_has_char && !n_ends_hyph &&
                (n_label_size <= LabelMax);
   end

   always_comb begin
      in_valid_in   = take_req ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
      label_size_in = label_size_ff;
      has_char_in   = has_char_ff;
      ends_hyph_in  = ends_hyph_ff;
      name_len_in   = name_len_ff;
      failed_in     = failed_ff;
      if (in_move) begin
         if (in_last_ff) begin
            label_size_in = '0;
            has_char_in   = 1'b0;
            ends_hyph_in  = 1'b0;
            name_len_in   = '0;
            failed_in     = 1'b0;
         end else begin
            label_size_in = n_label_size;
            has_char_in   = n_has_char;
            ends_hyph_in  = n_ends_hyph;
            name_len_in   = n_name_len;
            failed_in     = n_failed;
         end
      end
      rsp_valid_in      = rsp_valid_ff;
      rsp_name_valid_in = rsp_name_valid_ff;
      if (out_free) begin
         rsp_valid_in = in_move && in_last_ff;
         if (in_move && in_last_ff) begin
            rsp_name_valid_in = verdict;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         label_size_ff <= '0;
         has_char_ff   <= 1'b0;
         ends_hyph_ff  <= 1'b0;
         name_len_ff   <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         label_size_ff <= label_size_in;
         has_char_ff   <= has_char_in;
         ends_hyph_ff  <= ends_hyph_in;
         name_len_ff   <= name_len_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold payload while the input register is occupied
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff  <= req_name_byte;
         in_last_ff  <= req_last_byte;
         in_empty_ff <= req_empty_name;
      end
      rsp_name_valid_ff <= rsp_name_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_valid = rsp_name_valid_ff;

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for the host name label validator: directed and random names against a predictor.
module tb;
   import hlv_pkg::*;

   localparam int NAME_LIMIT   = 255;
   localparam int LABEL_LIMIT  = 63;
   localparam int PHASE_WORDS  = 570;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      byte_type b;
      logic     empty;
   } name_word_type;

   class hostname_scoreboard_type;
      label_size_type label_size;
      name_len_type   name_len;
      logic           has_char;
      logic           ends_hyphen;
      logic           failed;
      logic           pending_verdicts[$];
      int             verdicts_seen;
      int             valid_seen;
      int             mismatches;

      function new();
         clear_name();
         verdicts_seen = 0;
         valid_seen = 0;
         mismatches = 0;
      endfunction

      function void clear_label();
         label_size = '0;
         has_char = 1'b0;
         ends_hyphen = 1'b0;
      endfunction

      function void clear_name();
         clear_label();
         name_len = '0;
         failed = 1'b0;
      endfunction

      function logic label_good();
         return has_char && !ends_hyphen && (label_size <= LABEL_LIMIT);
      endfunction

      function void bump_label();
         if (label_size <= LABEL_LIMIT) label_size = label_size + 1'b1;
      endfunction

      function logic letter_or_digit(byte_type c);
         return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction

      function void note_word(byte_type c, logic last, logic empty);
         if (empty) begin
            failed = 1'b1;
         end else begin
            if (name_len <= NAME_LIMIT) name_len = name_len + 1'b1;
            if (!failed) begin
               if (c <= CHAR_SPACE || c >= CHAR_DEL) begin
                  failed = 1'b1;
               end else if (c == CHAR_DOT) begin
                  if (label_good()) clear_label();
                  else failed = 1'b1;
               end else if (letter_or_digit(c)) begin
                  bump_label();
                  has_char = 1'b1;
                  ends_hyphen = 1'b0;
               end else if (c == CHAR_HYPHEN) begin
                  if (!has_char) begin
                     failed = 1'b1;
                  end else begin
                     bump_label();
                     ends_hyphen = 1'b1;
                  end
               end else begin
                  failed = 1'b1;
               end
            end
         end
         if (last) begin
            pending_verdicts.push_back(!failed && (name_len <= NAME_LIMIT) && label_good());
            clear_name();
         end
      endfunction

      function void check_verdict(logic got);
         logic want;
         verdicts_seen++;
         if (got === 1'b1) valid_seen++;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: verdict %b with no name pending", $time, got);
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: name_valid expected %b, got %b", $time, want, got);
            end
         end
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   byte_type req_name_byte = '0;
   logic     req_last_byte = 1'b0;
   logic     req_empty_name = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic     rsp_name_valid;

   hostname_scoreboard_type board;
   name_word_type           name_q[$];
   int                      send_idle = 0;
   int                      recv_idle = 0;
   int                      words_sent = 0;
   int                      names_sent = 0;
   int                      cycle_count = 0;

   hostname_label_validator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_name_byte  (req_name_byte),
      .req_last_byte  (req_last_byte),
      .req_empty_name (req_empty_name),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_name_valid (rsp_name_valid)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_verdict(rsp_name_valid);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic byte_type rand_alnum();
      int r;
      r = $urandom_range(61);
      if (r < 10) return byte_type'("0" + r);
      if (r < 36) return byte_type'("A" + r - 10);
      return byte_type'("a" + r - 36);
   endfunction

   task automatic push_word(input byte_type c, input logic e);
      name_word_type w;
      w.b = c;
      w.empty = e;
      name_q.push_back(w);
   endtask

   task automatic spell(input string s);
      for (int i = 0; i < s.len(); i++) push_word(byte_type'(s[i]), 1'b0);
   endtask

   // hold the word until taken, then advance to the next falling edge
   task automatic send_word(input byte_type c, input logic last, input logic e);
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_name_byte <= c;
      req_last_byte <= last;
      req_empty_name <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(c, last, e);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_name();
      for (int i = 0; i < name_q.size(); i++)
         send_word(name_q[i].b, i == name_q.size() - 1, name_q[i].empty);
      name_q.delete();
      names_sent++;
   endtask

   task automatic long_name();
      int total;
      case ($urandom_range(4))
         0: total = NAME_LIMIT - 1;
         1: total = NAME_LIMIT;
         2: total = NAME_LIMIT + 1;
         3: total = NAME_LIMIT + 2;
         default: total = NAME_LIMIT + 45;
      endcase
      for (int i = 0; i < total; i++)
         push_word((i == total - 1 || i % 64 != 63) ? rand_alnum() : CHAR_DOT, 1'b0);
   endtask

   task automatic wellformed_name();
      int labels;
      int len;
      int pos;
      byte_type c;
      labels = $urandom_range(1, 4);
      for (int l = 0; l < labels; l++) begin
         if (l > 0) push_word(CHAR_DOT, 1'b0);
         len = ($urandom_range(19) == 0) ? $urandom_range(LABEL_LIMIT - 2, LABEL_LIMIT + 2)
                                         : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            c = rand_alnum();
            if (i > 0 && i < len - 1 && $urandom_range(3) == 0) c = CHAR_HYPHEN;
            push_word(c, 1'b0);
         end
      end
      if ($urandom_range(99) < 15) begin
         pos = $urandom_range(name_q.size() - 1);
         case ($urandom_range(3))
            0: name_q[pos].b = byte_type'($urandom_range(255));
            1: name_q[pos].b = CHAR_HYPHEN;
            2: name_q[pos].b = CHAR_DOT;
            default: name_q[pos].empty = 1'b1;
         endcase
      end
   endtask

   task automatic noise_name();
      int len;
      byte_type c;
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(3))
            0: c = CHAR_DOT;
            1: c = CHAR_HYPHEN;
            2: c = rand_alnum();
            default: c = byte_type'($urandom_range(255));
         endcase
         push_word(c, $urandom_range(11) == 0);
      end
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct);
      int goal;
      int r;
      send_idle = sender_pct;
      recv_idle = receiver_pct;
      goal = words_sent + PHASE_WORDS;
      long_name();
      send_name();
      while (words_sent < goal) begin
         r = $urandom_range(149);
         if (r == 0) long_name();
         else if (r < 110) wellformed_name();
         else noise_name();
         send_name();
      end
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 9;
      recv_idle = 76;

      push_word(8'hff, 1'b1);
      send_name();
      spell("a");
      send_name();
      push_word(8'h00, 1'b1);
      spell("a");
      send_name();
      spell("-a");
      send_name();
      spell("a-");
      send_name();
      spell("a.");
      send_name();
      spell(".a");
      send_name();
      push_word(8'h00, 1'b0);
      send_name();
      push_word(CHAR_SPACE, 1'b0);
      send_name();
      push_word(CHAR_DEL, 1'b0);
      send_name();
      push_word(CHAR_HIGH, 1'b0);
      send_name();
      push_word(8'hff, 1'b0);
      send_name();
      spell("9_");
      send_name();
      spell("a-b.Z");
      send_name();

      run_phase(9, 76);
      run_phase(76, 9);
      run_phase(0, 0);
      req_valid <= 1'b0;

      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words in %0d names under three idle mixes, long names included",
               words_sent, names_sent);
      $display("Checked %0d verdicts (%0d valid), %0d mismatches",
               board.verdicts_seen, board.valid_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
src/hlv_pkg.sv
src/hostname_label_validator_unit.sv
sim/tb.sv
